[rtl/rthd_pkg.sv]
`default_nettype none
package rthd_pkg;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned TOL_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOL    = 3'd6;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vertex_a_x;
    logic signed [FIELD_W-1:0] vertex_a_y;
    logic signed [FIELD_W-1:0] vertex_a_z;
    logic signed [FIELD_W-1:0] vertex_b_x;
    logic signed [FIELD_W-1:0] vertex_b_y;
    logic signed [FIELD_W-1:0] vertex_b_z;
    logic signed [FIELD_W-1:0] vertex_c_x;
    logic signed [FIELD_W-1:0] vertex_c_y;
    logic signed [FIELD_W-1:0] vertex_c_z;
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
  } tri_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage
`default_nettype wire

[rtl/rthd_dly.sv]
`default_nettype none
module rthd_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sh_q [N];

  always_ff @(posedge clk_i) begin
    sh_q[0] <= d_i;
    for (int i = 1; i < N; i++) begin
      sh_q[i] <= sh_q[i-1];
    end
  end

  assign q_o = sh_q[N-1];

endmodule
`default_nettype wire

[rtl/rthd_mul.sv]
`default_nettype none
// unsigned multiply, four registered partial products then a registered sum
module rthd_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  wire logic               clk_i,
  input  wire logic [AW-1:0]      a_i,
  input  wire logic [BW-1:0]      b_i,
  output logic      [AW+BW-1:0]   p_o
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AH+BH-1:0] hh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AL+BH-1:0] lh_q;
  logic [AL+BL-1:0] ll_q;
  logic [PW-1:0]    p_q;

  always_ff @(posedge clk_i) begin
    hh_q <= a_i[AW-1:AL] * b_i[BW-1:BL];
    hl_q <= a_i[AW-1:AL] * b_i[BL-1:0];
    lh_q <= a_i[AL-1:0] * b_i[BW-1:BL];
    ll_q <= a_i[AL-1:0] * b_i[BL-1:0];
    p_q  <= (PW'(hh_q) << (AL + BL)) + (PW'(hl_q) << AL) + (PW'(lh_q) << BL) + PW'(ll_q);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

[rtl/rthd_div.sv]
`default_nettype none
// restoring divider, one quotient bit per stage
module rthd_div #(
  parameter int unsigned NW = 83,
  parameter int unsigned DW = 66
) (
  input  wire logic          clk_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [NW-1:0] rest_q [NW];
  logic [NW-1:0] quo_q  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DW-1:0] rem_c, den_c;
    logic [NW-1:0] rest_c, quo_c;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_c  = '0;
      assign den_c  = den_i;
      assign rest_c = num_i;
      assign quo_c  = '0;
    end else begin : g_next
      assign rem_c  = rem_q[s-1];
      assign den_c  = den_q[s-1];
      assign rest_c = rest_q[s-1];
      assign quo_c  = quo_q[s-1];
    end

    assign rem_sh = {rem_c, rest_c[NW-1]};
    assign ge     = rem_sh >= (DW+1)'(den_c);

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? DW'(rem_sh - (DW+1)'(den_c)) : DW'(rem_sh);
      den_q[s]  <= den_c;
      rest_q[s] <= {rest_c[NW-2:0], 1'b0};
      quo_q[s]  <= {quo_c[NW-2:0], ge};
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule
`default_nettype wire

[rtl/rthd_sqrt.sv]
`default_nettype none
// integer square root, one root bit per stage
module rthd_sqrt #(
  parameter int unsigned IW = 66
) (
  input  wire logic             clk_i,
  input  wire logic [IW-1:0]    v_i,
  output logic      [IW/2-1:0]  root_o
);

  localparam int unsigned OW = IW / 2;

  logic [OW+1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [IW-1:0] rest_q [OW];

  for (genvar s = 0; s < OW; s++) begin : g_st
    logic [OW+1:0] rem_c, rem_sh, trial;
    logic [OW-1:0] root_c;
    logic [IW-1:0] rest_c;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_c  = '0;
      assign root_c = '0;
      assign rest_c = v_i;
    end else begin : g_next
      assign rem_c  = rem_q[s-1];
      assign root_c = root_q[s-1];
      assign rest_c = rest_q[s-1];
    end

    assign rem_sh = {rem_c[OW-1:0], rest_c[IW-1:IW-2]};
    assign trial  = {root_c, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? rem_sh - trial : rem_sh;
      root_q[s] <= {root_c[OW-2:0], ge};
      rest_q[s] <= {rest_c[IW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[OW-1];

endmodule
`default_nettype wire

[rtl/rthd_heron.sv]
`default_nettype none
// Heron area of triangle (p, q, r)
module rthd_heron #(
  parameter int unsigned CW = 32,
  parameter int unsigned F  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic [3*CW-1:0]      p_i,
  input  wire logic [3*CW-1:0]      q_i,
  input  wire logic [3*CW-1:0]      r_i,
  output logic      [2*CW+3-F:0]    area_o
);

  localparam int unsigned EW  = CW + 1;
  localparam int unsigned SQW = 2 * CW + 1;
  localparam int unsigned SSW = 2 * CW + 2;
  localparam int unsigned HW  = CW + 2;
  localparam int unsigned MW  = 2 * HW;
  localparam int unsigned RW  = 2 * MW;
  localparam int unsigned AW  = (RW - 2 * F) / 2;

  logic [3*CW-1:0] ea [3];
  logic [3*CW-1:0] eb [3];
  logic [SQW-1:0]  sq_q  [3][3];
  logic [SSW-1:0]  ss_q  [3];
  logic [EW-1:0]   len   [3];
  logic [EW-1:0]   len_q [3];
  logic [HW-1:0]   half_q, hd_q;
  logic [HW-1:0]   dm_q  [3];
  logic            dn_q  [3];
  logic [MW-1:0]   p1_q, p2_q;
  logic            pos_q, pos_d;
  logic [RW-1:0]   rad;
  logic [AW-1:0]   root;

  assign ea[0] = p_i;
  assign eb[0] = q_i;
  assign ea[1] = q_i;
  assign eb[1] = r_i;
  assign ea[2] = r_i;
  assign eb[2] = p_i;

  for (genvar e = 0; e < 3; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_ax
      logic signed [EW-1:0]   dif;
      logic signed [2*EW-1:0] sqr;
      assign dif = EW'($signed(ea[e][k*CW +: CW])) - EW'($signed(eb[e][k*CW +: CW]));
      assign sqr = dif * dif;
      always_ff @(posedge clk_i) begin
        sq_q[e][k] <= SQW'(sqr);
      end
    end

    always_ff @(posedge clk_i) begin
      ss_q[e] <= SSW'(sq_q[e][0]) + SSW'(sq_q[e][1]) + SSW'(sq_q[e][2]);
    end

    rthd_sqrt #(.IW(SSW)) u_len (
      .clk_i  (clk_i),
      .v_i    (ss_q[e]),
      .root_o (len[e])
    );
  end

  always_ff @(posedge clk_i) begin
    half_q <= HW'(((EW+2)'(len[0]) + (EW+2)'(len[1]) + (EW+2)'(len[2])) >> 1);
    for (int e = 0; e < 3; e++) begin
      len_q[e] <= len[e];
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_gap
    logic signed [HW:0] d;
    assign d = $signed({1'b0, half_q}) - $signed((HW+1)'(len_q[e]));
    always_ff @(posedge clk_i) begin
      dn_q[e] <= d[HW];
      dm_q[e] <= d[HW] ? HW'(-d) : HW'(d);
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q  <= half_q;
    p1_q  <= hd_q * dm_q[0];
    p2_q  <= dm_q[1] * dm_q[2];
    pos_q <= !(dn_q[0] ^ dn_q[1] ^ dn_q[2]);
  end

  rthd_mul #(.AW(MW), .BW(MW)) u_rad (
    .clk_i (clk_i),
    .a_i   (p1_q),
    .b_i   (p2_q),
    .p_o   (rad)
  );

  rthd_sqrt #(.IW(RW - 2 * F)) u_area (
    .clk_i  (clk_i),
    .v_i    (rad[RW-1:2*F]),
    .root_o (root)
  );

  rthd_dly #(.W(1), .N(2 + AW)) u_pos (
    .clk_i (clk_i),
    .d_i   (pos_q),
    .q_o   (pos_d)
  );

  assign area_o = pos_d ? root : '0;

endmodule
`default_nettype wire

[rtl/ray_triangle_hit_distance.sv]
// channel   | signals                          | transfer
// ----------+----------------------------------+-------------------------------
// triangle  | start, busy, tri_i               | start && !busy at clock edge
// result    | done_o, res_o                    | done_o high for one cycle
// config    | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i at clock edge
//
// Fully pipelined: one triangle per cycle; the delay from a transfer to its result is set
// by the 2*COORD_WIDTH + FRAC_BITS + 3 divider stages and the two square-root chains
// inside each Heron unit.
// busy stays low; the pipeline never stalls and the receiver cannot stall.
// rst_ni clears the valid chain and loads the register reset values.
`default_nettype none
module ray_triangle_hit_distance #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire rthd_pkg::tri_t                 tri_i,
  output logic                                done_o,
  output rthd_pkg::res_t                      res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rthd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rthd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned FW   = rthd_pkg::FIELD_W;
  localparam int unsigned EW   = CW + 1;
  localparam int unsigned DENW = 2 * CW + 2;
  localparam int unsigned NUMW = 2 * CW + 3;
  localparam int unsigned DVW  = NUMW + F;
  localparam int unsigned TW   = CW + F + 2;
  localparam int unsigned PMW  = CW + TW;
  localparam int unsigned PSW  = 2 * CW + 4;
  localparam int unsigned AW   = 2 * CW + 4 - F;
  localparam int unsigned HL   = CW + 8 + AW;
  localparam int unsigned LAT  = 8 + DVW + HL;
  localparam int unsigned DXW  = (EW > rthd_pkg::DIST_W) ? EW : rthd_pkg::DIST_W;
  localparam int unsigned CMW  = (AW + 3 > rthd_pkg::TOL_W) ? AW + 3 : rthd_pkg::TOL_W;

  localparam logic signed [PSW-1:0] P_TOP = signed'((PSW'(1) << (CW - 1)) - PSW'(1));
  localparam logic signed [PSW-1:0] P_BOT = -P_TOP - PSW'(1);

  logic [FW-1:0]               org_q [3];
  logic [FW-1:0]               dir_q [3];
  logic [rthd_pkg::TOL_W-1:0]  tol_q;
  logic [LAT-1:0]              vld_q;

  logic signed [CW-1:0] org_c [3];
  logic signed [CW-1:0] dir_c [3];
  logic [CW-1:0]        dmag  [3];
  logic signed [CW-1:0] nrm_c [3];
  logic signed [CW-1:0] v0_c  [3];

  logic signed [2*CW-1:0] nd_q [3];
  logic signed [2*CW:0]   nv_q [3];
  logic signed [DENW-1:0] den_q;
  logic signed [NUMW-1:0] num_q;
  logic                   par_q, neg_q, par_d, neg_d;
  logic [DVW-1:0]         dvd_q, quo;
  logic [DENW-1:0]        dvs_q;
  logic [TW-1:0]          tmag_q;
  logic [PMW-1:0]         prod [3];
  logic signed [CW-1:0]   p_q  [3];

  logic [3*CW-1:0] va_f, vb_f, vc_f, va_d, vb_d, vc_d, pt_f;
  logic [AW-1:0]   a_full, a_e1, a_e2, a_e3;
  logic [2*EW-1:0] dsq_q [3];
  logic [2*EW-1:0] dss_q;
  logic [EW-1:0]   droot, droot_d;

  logic [AW+1:0]         esum;
  logic signed [AW+2:0]  gap;
  logic [AW+2:0]         gmag;

  rthd_pkg::res_t res_d, res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        dir_q[k] <= '0;
      end
      tol_q <= rthd_pkg::TOL_RESET;
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start && !busy};
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rthd_pkg::CFG_ORIGIN_X:    org_q[0] <= cfg_data_i;
          rthd_pkg::CFG_ORIGIN_Y:    org_q[1] <= cfg_data_i;
          rthd_pkg::CFG_ORIGIN_Z:    org_q[2] <= cfg_data_i;
          rthd_pkg::CFG_DIRECTION_X: dir_q[0] <= cfg_data_i;
          rthd_pkg::CFG_DIRECTION_Y: dir_q[1] <= cfg_data_i;
          rthd_pkg::CFG_DIRECTION_Z: dir_q[2] <= cfg_data_i;
          rthd_pkg::CFG_AREA_TOL:    tol_q    <= cfg_data_i[rthd_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign nrm_c[0] = $signed(CW'($unsigned(tri_i.normal_x)));
  assign nrm_c[1] = $signed(CW'($unsigned(tri_i.normal_y)));
  assign nrm_c[2] = $signed(CW'($unsigned(tri_i.normal_z)));
  assign v0_c[0]  = $signed(CW'($unsigned(tri_i.vertex_a_x)));
  assign v0_c[1]  = $signed(CW'($unsigned(tri_i.vertex_a_y)));
  assign v0_c[2]  = $signed(CW'($unsigned(tri_i.vertex_a_z)));

  assign va_f = {CW'($unsigned(tri_i.vertex_a_z)), CW'($unsigned(tri_i.vertex_a_y)),
                 CW'($unsigned(tri_i.vertex_a_x))};
  assign vb_f = {CW'($unsigned(tri_i.vertex_b_z)), CW'($unsigned(tri_i.vertex_b_y)),
                 CW'($unsigned(tri_i.vertex_b_x))};
  assign vc_f = {CW'($unsigned(tri_i.vertex_c_z)), CW'($unsigned(tri_i.vertex_c_y)),
                 CW'($unsigned(tri_i.vertex_c_x))};

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [CW:0]     vo;
    logic [PMW-F-1:0]       pmag;
    logic signed [PSW-1:0]  sv, psum;
    logic signed [EW-1:0]   dd;
    logic signed [2*EW-1:0] dsq;

    assign org_c[k] = $signed(CW'(org_q[k]));
    assign dir_c[k] = $signed(CW'(dir_q[k]));
    assign dmag[k]  = dir_c[k][CW-1] ? CW'(-dir_c[k]) : CW'(dir_c[k]);
    assign vo       = EW'(v0_c[k]) - EW'(org_c[k]);

    always_ff @(posedge clk_i) begin
      nd_q[k] <= nrm_c[k] * dir_c[k];
      nv_q[k] <= (2*CW+1)'(nrm_c[k]) * (2*CW+1)'(vo);
    end

    rthd_mul #(.AW(CW), .BW(TW)) u_dt (
      .clk_i (clk_i),
      .a_i   (dmag[k]),
      .b_i   (tmag_q),
      .p_o   (prod[k])
    );

    assign pmag = prod[k][PMW-1:F];
    assign sv   = (dir_c[k][CW-1] ^ neg_d) ? -$signed(PSW'(pmag)) : $signed(PSW'(pmag));
    assign psum = sv + PSW'(org_c[k]);

    always_ff @(posedge clk_i) begin
      if (psum > P_TOP) begin
        p_q[k] <= CW'(P_TOP);
      end else if (psum < P_BOT) begin
        p_q[k] <= CW'(P_BOT);
      end else begin
        p_q[k] <= CW'(psum);
      end
    end

    assign dd  = EW'(org_c[k]) - EW'(p_q[k]);
    assign dsq = dd * dd;
    always_ff @(posedge clk_i) begin
      dsq_q[k] <= dsq;
    end

    assign pt_f[k*CW +: CW] = p_q[k];
  end

  always_ff @(posedge clk_i) begin
    den_q  <= DENW'(nd_q[0]) + DENW'(nd_q[1]) + DENW'(nd_q[2]);
    num_q  <= NUMW'(nv_q[0]) + NUMW'(nv_q[1]) + NUMW'(nv_q[2]);
    par_q  <= den_q == '0;
    neg_q  <= num_q[NUMW-1] ^ den_q[DENW-1];
    dvd_q  <= DVW'(num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q)) << F;
    dvs_q  <= den_q[DENW-1] ? DENW'(-den_q) : DENW'(den_q);
    tmag_q <= (|quo[DVW-1:TW-1]) ? {1'b1, (TW-1)'(0)} : quo[TW-1:0];
    dss_q  <= dsq_q[0] + dsq_q[1] + dsq_q[2];
  end

  rthd_div #(.NW(DVW), .DW(DENW)) u_div (
    .clk_i (clk_i),
    .num_i (dvd_q),
    .den_i (dvs_q),
    .quo_o (quo)
  );

  rthd_dly #(.W(1), .N(3 + DVW)) u_neg (
    .clk_i (clk_i),
    .d_i   (neg_q),
    .q_o   (neg_d)
  );

  rthd_dly #(.W(1), .N(4 + DVW + HL)) u_par (
    .clk_i (clk_i),
    .d_i   (par_q),
    .q_o   (par_d)
  );

  rthd_dly #(.W(9 * CW), .N(7 + DVW)) u_vtx (
    .clk_i (clk_i),
    .d_i   ({vc_f, vb_f, va_f}),
    .q_o   ({vc_d, vb_d, va_d})
  );

  rthd_heron #(.CW(CW), .F(F)) u_full (
    .clk_i (clk_i), .p_i (va_d), .q_i (vb_d), .r_i (vc_d), .area_o (a_full)
  );
  rthd_heron #(.CW(CW), .F(F)) u_e1 (
    .clk_i (clk_i), .p_i (va_d), .q_i (vb_d), .r_i (pt_f), .area_o (a_e1)
  );
  rthd_heron #(.CW(CW), .F(F)) u_e2 (
    .clk_i (clk_i), .p_i (vb_d), .q_i (vc_d), .r_i (pt_f), .area_o (a_e2)
  );
  rthd_heron #(.CW(CW), .F(F)) u_e3 (
    .clk_i (clk_i), .p_i (vc_d), .q_i (va_d), .r_i (pt_f), .area_o (a_e3)
  );

  rthd_sqrt #(.IW(2 * EW)) u_dist (
    .clk_i  (clk_i),
    .v_i    (dss_q),
    .root_o (droot)
  );

  rthd_dly #(.W(EW), .N(5 + AW)) u_dist_dly (
    .clk_i (clk_i),
    .d_i   (droot),
    .q_o   (droot_d)
  );

  assign esum = (AW+2)'(a_e1) + (AW+2)'(a_e2) + (AW+2)'(a_e3);
  assign gap  = $signed((AW+3)'(a_full)) - $signed((AW+3)'(esum));
  assign gmag = gap[AW+2] ? (AW+3)'(-gap) : (AW+3)'(gap);

  always_comb begin
    res_d.status   = rthd_pkg::ST_HIT;
    res_d.distance = '0;
    if (par_d) begin
      res_d.status = rthd_pkg::ST_PARALLEL;
    end else if (CMW'(gmag) > CMW'(tol_q)) begin
      res_d.status = rthd_pkg::ST_OUTSIDE;
    end else if (DXW'(droot_d) > DXW'({rthd_pkg::DIST_W{1'b1}})) begin
      res_d.distance = '1;
    end else begin
      res_d.distance = rthd_pkg::DIST_W'(droot_d);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = vld_q[LAT-1];
  assign res_o  = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done_o)
    else $error("triangle transfer without result");

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != rthd_pkg::ST_HIT |-> res_o.distance == '0)
    else $error("distance set on a miss");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.status == rthd_pkg::ST_HIT || res_o.status == rthd_pkg::ST_PARALLEL
               || res_o.status == rthd_pkg::ST_OUTSIDE)
    else $error("bad status code");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import rthd_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef wide_t vec3_t[3];

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int PHASES       = 8;
  localparam int PER_PHASE    = 165;
  localparam int DRAIN        = 1000;
  localparam int CYCLE_LIMIT  = 900000;
  localparam int FRAC_BITS_TB = 16;

  class hit_scoreboard;
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
    logic [TOL_W-1:0]   tol;
    res_t               pending[$];
    int                 errors;

    function new();
      foreach (org[k]) begin
        org[k] = '0;
        dir[k] = '0;
      end
      tol = TOL_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_ORIGIN_X:    org[0] = data;
        CFG_ORIGIN_Y:    org[1] = data;
        CFG_ORIGIN_Z:    org[2] = data;
        CFG_DIRECTION_X: dir[0] = data;
        CFG_DIRECTION_Y: dir[1] = data;
        CFG_DIRECTION_Z: dir[2] = data;
        CFG_AREA_TOL:    tol = data[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    function wide_t isqrt(wide_t v);
      wide_t root, b, trial;
      root = 0;
      b = wide_t'(1) <<< 254;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        trial = root + b;
        if (v >= trial) begin
          v = v - trial;
          root = (root >>> 1) + b;
        end else begin
          root = root >>> 1;
        end
        b = b >>> 2;
      end
      return root;
    endfunction

    function wide_t dot3(vec3_t p, vec3_t q);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function wide_t span(vec3_t p, vec3_t q);
      vec3_t g;
      foreach (g[k]) g[k] = p[k] - q[k];
      return isqrt(dot3(g, g));
    endfunction

    function wide_t heron(vec3_t p, vec3_t q, vec3_t r);
      wide_t la, lb, lc, half, rad;
      la = span(p, q);
      lb = span(q, r);
      lc = span(r, p);
      half = (la + lb + lc) >>> 1;
      rad = (half * (half - la)) * ((half - lb) * (half - lc));
      if (rad <= 0) return 0;
      return isqrt(rad >>> (2 * FRAC_BITS_TB));
    endfunction

    function res_t predict(tri_t tr);
      vec3_t o, d, va, vb, vc, n, p;
      wide_t den, num, t, m, full, sum, gap, dlen;
      res_t r;
      foreach (o[k]) begin
        o[k] = org[k];
        d[k] = dir[k];
      end
      va[0] = tr.vertex_a_x; va[1] = tr.vertex_a_y; va[2] = tr.vertex_a_z;
      vb[0] = tr.vertex_b_x; vb[1] = tr.vertex_b_y; vb[2] = tr.vertex_b_z;
      vc[0] = tr.vertex_c_x; vc[1] = tr.vertex_c_y; vc[2] = tr.vertex_c_z;
      n[0] = tr.normal_x;    n[1] = tr.normal_y;    n[2] = tr.normal_z;
      r.status = ST_HIT;
      r.distance = '0;
      den = dot3(n, d);
      if (den == 0) begin
        r.status = ST_PARALLEL;
        return r;
      end
      num = dot3(n, va) - dot3(n, o);
      t = (num <<< FRAC_BITS_TB) / den;
      foreach (p[k]) begin
        m = d[k] * t;
        m = (m < 0) ? -((-m) >>> FRAC_BITS_TB) : (m >>> FRAC_BITS_TB);
        p[k] = o[k] + m;
        if (p[k] > 64'sh7FFFFFFF) p[k] = 64'sh7FFFFFFF;
        if (p[k] < -64'sh80000000) p[k] = -64'sh80000000;
      end
      full = heron(va, vb, vc);
      sum = heron(va, vb, p) + heron(vb, vc, p) + heron(vc, va, p);
      gap = full - sum;
      if (gap < 0) gap = -gap;
      if (gap > wide_t'({1'b0, tol})) begin
        r.status = ST_OUTSIDE;
        return r;
      end
      dlen = span(o, p);
      r.distance = (dlen > 64'shFFFFFFFF) ? 32'hFFFFFFFF : dlen[31:0];
      return r;
    endfunction

    function void note(tri_t tr);
      pending.push_back(predict(tr));
    endfunction

    function void check(res_t got);
      res_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing pending: status %0d distance %h",
               got.status, got.distance);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status expected %0d actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.distance !== exp_r.distance) begin
        $error("distance expected %h actual %h", exp_r.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  tri_t                  tri_i = '0;
  logic                  done_o;
  res_t                  res_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  hit_scoreboard sb = new();
  int unsigned cycles = 0;

  ray_triangle_hit_distance DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .tri_i(tri_i),
    .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(res_o);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_tri(tri_t tr);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    tri_i <= tr;
    do @(posedge clk_i); while (busy);
    sb.note(tr);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                         logic [31:0] tol);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIRECTION_X, dx);
    write_reg(CFG_DIRECTION_Y, dy);
    write_reg(CFG_DIRECTION_Z, dz);
    write_reg(CFG_AREA_TOL, tol);
  endtask

  function automatic tri_t make_tri(logic [31:0] a[3], logic [31:0] b[3], logic [31:0] c[3],
                                    logic [31:0] n[3]);
    tri_t tr;
    tr.vertex_a_x = a[0]; tr.vertex_a_y = a[1]; tr.vertex_a_z = a[2];
    tr.vertex_b_x = b[0]; tr.vertex_b_y = b[1]; tr.vertex_b_z = b[2];
    tr.vertex_c_x = c[0]; tr.vertex_c_y = c[1]; tr.vertex_c_z = c[2];
    tr.normal_x = n[0];   tr.normal_y = n[1];   tr.normal_z = n[2];
    return tr;
  endfunction

  function automatic tri_t noise_tri();
    tri_t tr;
    tr = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return tr;
  endfunction

  function automatic longint soff(int bits);
    longint v;
    v = longint'($urandom_range(0, (1 << bits) - 1));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // triangle built around a point on the ray, normal from the edge cross product
  function automatic tri_t aimed_tri();
    longint t, pt[3], va[3], vb[3], vc[3], e1[3], e2[3], cr[3];
    logic [31:0] a[3], b[3], c[3], n[3];
    int sc, sh;
    t = longint'($urandom_range(0, 1 << 18));
    if ($urandom_range(0, 5) == 0) t = -t;
    sc = $urandom_range(6, 22);
    for (int k = 0; k < 3; k++) begin
      pt[k] = longint'(sb.org[k]) + ((longint'(sb.dir[k]) * t) >>> 16);
      va[k] = pt[k] + soff(sc);
      vb[k] = pt[k] + soff(sc);
      vc[k] = pt[k] + soff(sc);
      e1[k] = vb[k] - va[k];
      e2[k] = vc[k] - va[k];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sh = 0;
    while (sh < 60 && ((cr[0] >>> sh) > 64'sh3FFFFFFF || (cr[0] >>> sh) < -64'sh40000000 ||
                       (cr[1] >>> sh) > 64'sh3FFFFFFF || (cr[1] >>> sh) < -64'sh40000000 ||
                       (cr[2] >>> sh) > 64'sh3FFFFFFF || (cr[2] >>> sh) < -64'sh40000000))
      sh++;
    for (int k = 0; k < 3; k++) begin
      a[k] = va[k][31:0];
      b[k] = vb[k][31:0];
      c[k] = vc[k][31:0];
      n[k] = 32'(cr[k] >>> sh);
    end
    return make_tri(a, b, c, n);
  endfunction

  function automatic logic [31:0] rnd_dir();
    if ($urandom_range(0, 6) == 0) return '0;
    return 32'(soff($urandom_range(4, 18)));
  endfunction

  initial begin
    logic [31:0] a[3], b[3], c[3], n[3];
    logic [31:0] tolv;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ray has zero direction: everything parallel
    send_tri(noise_tri());
    a = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    send_tri(make_tri(a, a, a, a));
    drain();

    set_ray(0, 0, 0, 0, 0, 32'h0001_0000, 32'd66);
    write_reg(CFG_UNUSED, 32'hFFFFFFFF);
    // plain hit at z = 5
    a = '{-32'sh40000, -32'sh40000, 32'h50000};
    b = '{32'h40000, -32'sh40000, 32'h50000};
    c = '{32'h0, 32'h40000, 32'h50000};
    n = '{32'h0, 32'h0, 32'h10000};
    send_tri(make_tri(a, b, c, n));
    // hit behind the origin
    a[2] = -32'sh50000; b[2] = -32'sh50000; c[2] = -32'sh50000;
    send_tri(make_tri(a, b, c, n));
    // outside
    a = '{32'h640000, 32'h0, 32'h50000};
    b = '{32'h6A0000, 32'h0, 32'h50000};
    c = '{32'h670000, 32'h40000, 32'h50000};
    send_tri(make_tri(a, b, c, n));
    // degenerate triangle
    send_tri(make_tri(a, a, a, n));
    // zero normal
    n = '{32'h0, 32'h0, 32'h0};
    send_tri(make_tri(a, b, c, n));
    // normal perpendicular to the ray
    n = '{32'h10000, 32'h0, 32'h0};
    send_tri(make_tri(a, b, c, n));
    // far hit, clamped, and field extremes
    a = '{32'h0, 32'h0, 32'h7FFFFFFF};
    n = '{32'h0, 32'h0, 32'h1};
    send_tri(make_tri(a, a, a, n));
    a = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    b = '{32'h80000000, 32'h80000000, 32'h80000000};
    send_tri(make_tri(a, a, a, a));
    send_tri(make_tri(b, b, b, b));
    send_tri(make_tri(a, b, a, b));
    send_tri(make_tri(b, a, b, a));
    drain();

    // long distance: saturated
    set_ray(32'h80000000, 32'h80000000, 32'h80000000,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    a = '{32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0000};
    b = '{32'h7FFF0000, 32'h80000000, 32'h7FFF0000};
    c = '{32'h80000000, 32'h7FFF0000, 32'h7FFF0000};
    n = '{32'h0, 32'h0, 32'h10000};
    send_tri(make_tri(a, b, c, n));
    send_tri(make_tri(b, c, a, n));
    for (int i = 0; i < 4; i++) send_tri(aimed_tri());
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        3: tolv = 32'h0;
        4: tolv = 32'h7FFFFFFF;
        default: tolv = $urandom_range(0, 1 << $urandom_range(4, 24));
      endcase
      if (ph == 1)
        set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, tolv);
      else if (ph == 2)
        set_ray(32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000, tolv);
      else
        set_ray(32'(soff(22)), 32'(soff(22)), 32'(soff(22)),
                rnd_dir(), rnd_dir(), rnd_dir(), tolv);
      for (int i = 0; i < PER_PHASE; i++)
        send_tri(($urandom_range(0, 3) == 0) ? noise_tri() : aimed_tri());
      drain();
    end

    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[ray_triangle_hit_distance.f]
rtl/rthd_pkg.sv
rtl/rthd_dly.sv
rtl/rthd_mul.sv
rtl/rthd_div.sv
rtl/rthd_sqrt.sv
rtl/rthd_heron.sv
rtl/ray_triangle_hit_distance.sv
tb/sv/tb.sv
